/* rtl/btc_pkg.sv */
// Shared types, operation codes and reset constants for the button click tracker.
package btc_pkg;

  localparam int BUTTON_COUNT_DEF = 5;
  localparam int BUTTON_COUNT_MAX = 8;
  localparam int FUNC_W = 3;
  localparam int INDEX_W = 3;
  localparam int TICK_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Operation codes carried in func
  localparam logic [FUNC_W-1:0] FUNC_EVENT         = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_HELD          = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_JUST_RELEASED = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_JUST_PRESSED  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DOUBLE_CLICK  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR         = 3'd5;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MOUSE_ENABLED       = 2'd0;
  localparam logic [1:0] REG_DOUBLE_CLICK_WINDOW = 2'd1;
  localparam logic [1:0] REG_HOLD_WINDOW         = 2'd2;
  localparam logic [1:0] REG_RECENT_WINDOW       = 2'd3;

  // Register reset values
  localparam logic [TICK_W-1:0] DOUBLE_CLICK_WINDOW_RST = 32'd500;
  localparam logic [TICK_W-1:0] HOLD_WINDOW_RST         = 32'd60000;
  localparam logic [TICK_W-1:0] RECENT_WINDOW_RST       = 32'd100;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic do_event;
    logic do_clear;
    logic do_query;
  } dp_cmd_t;

  // Datapath to controller: decoded facts about the held request
  typedef struct packed {
    logic is_event;
    logic is_clear;
    logic is_query;
    logic in_range;
  } dp_status_t;

endpackage

/* rtl/btc_ctrl.sv */
// Controller state machine: sequences capture and execution of one request.
module btc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                mouse_enabled,
  input  btc_pkg::dp_status_t status,
  output btc_pkg::dp_cmd_t    cmd,
  output logic                busy
);
  import btc_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Drive commands
  always_comb begin
    cmd = '0;
    busy = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_EXEC: begin
        busy = 1'b1;
        cmd.do_event = status.is_event & status.in_range;
        cmd.do_clear = status.is_clear & status.in_range;
        cmd.do_query = status.is_query & status.in_range & mouse_enabled;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/btc_dp.sv */
// Datapath: request register, per-button state, window compares and answer register.
module btc_dp #(
  parameter int BUTTON_COUNT = btc_pkg::BUTTON_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  btc_pkg::dp_cmd_t             cmd,
  input  logic [btc_pkg::FUNC_W-1:0]   func,
  input  logic [btc_pkg::INDEX_W-1:0]  button_index,
  input  logic                         pressed,
  input  logic [btc_pkg::TICK_W-1:0]   tick_now,
  input  logic [btc_pkg::TICK_W-1:0]   double_click_window,
  input  logic [btc_pkg::TICK_W-1:0]   hold_window,
  input  logic [btc_pkg::TICK_W-1:0]   recent_window,
  output btc_pkg::dp_status_t          status,
  output logic                         done,
  output logic                         answer
);
  import btc_pkg::*;

  localparam int BIDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam logic [INDEX_W:0] COUNT = (INDEX_W + 1)'(BUTTON_COUNT);

  // Held request
  logic [FUNC_W-1:0]  func_q;
  logic [INDEX_W-1:0] index_q;
  logic               pressed_q;
  logic [TICK_W-1:0]  tick_q;

  // Per-button state
  logic [TICK_W-1:0]  last_time  [BUTTON_COUNT];
  logic               released   [BUTTON_COUNT];
  logic               just_press [BUTTON_COUNT];
  logic               dbl_click  [BUTTON_COUNT];

  logic [BIDX_W-1:0]  sel;
  logic [TICK_W-1:0]  t_sel;
  logic               rel_sel;
  logic               jp_sel;
  logic               dc_sel;
  logic [TICK_W-1:0]  window;
  logic [TICK_W-1:0]  limit;
  logic               before_limit;
  logic               hit;
  logic               clear_all;
  logic               clear_jp;
  logic               dbl_next;
  logic               exec_q;

  // Capture request fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q    <= func;
      index_q   <= button_index;
      pressed_q <= pressed;
      tick_q    <= tick_now;
    end
  end

  // Decode held request for the controller
  always_comb begin
    status.is_event = (func_q == FUNC_EVENT);
    status.is_clear = (func_q == FUNC_CLEAR);
    status.is_query = (func_q == FUNC_HELD) || (func_q == FUNC_JUST_RELEASED) ||
                      (func_q == FUNC_JUST_PRESSED) || (func_q == FUNC_DOUBLE_CLICK);
    status.in_range = ({1'b0, index_q} < COUNT);
  end

  // Read the addressed button
  assign sel     = index_q[BIDX_W-1:0];
  assign t_sel   = last_time[sel];
  assign rel_sel = released[sel];
  assign jp_sel  = just_press[sel];
  assign dc_sel  = dbl_click[sel];

  // Pick the window for this operation, then one add and compare
  always_comb begin
    case (func_q)
      FUNC_EVENT: window = double_click_window;
      FUNC_HELD:  window = hold_window;
      default:    window = recent_window;
    endcase
  end

  assign limit        = t_sel + window;
  assign before_limit = (tick_q < limit);
  assign dbl_next     = rel_sel & before_limit;

  // Query hit and its side effects
  always_comb begin
    hit       = 1'b0;
    clear_all = 1'b0;
    clear_jp  = 1'b0;
    case (func_q)
      FUNC_HELD: begin
        hit = before_limit & ~rel_sel;
      end
      FUNC_JUST_RELEASED: begin
        hit       = before_limit & rel_sel;
        clear_all = hit;
      end
      FUNC_JUST_PRESSED: begin
        // tick - recent < t, compared on the wrapped difference
        hit      = ((tick_q - recent_window) < t_sel) & ~rel_sel & jp_sel;
        clear_jp = hit;
      end
      FUNC_DOUBLE_CLICK: begin
        hit       = before_limit & dc_sel;
        clear_all = hit;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // Update button state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        last_time[i]  <= '0;
        released[i]   <= 1'b0;
        just_press[i] <= 1'b0;
        dbl_click[i]  <= 1'b0;
      end
    end else if (cmd.do_event) begin
      dbl_click[sel]  <= dbl_next;
      last_time[sel]  <= tick_q;
      released[sel]   <= ~pressed_q;
      just_press[sel] <= pressed_q;
    end else if (cmd.do_clear || (cmd.do_query && clear_all)) begin
      last_time[sel]  <= '0;
      released[sel]   <= 1'b0;
      just_press[sel] <= 1'b0;
      dbl_click[sel]  <= 1'b0;
    end else if (cmd.do_query && clear_jp) begin
      just_press[sel] <= 1'b0;
    end
  end

  // Track the execute cycle: the cycle after a load
  always_ff @(posedge clk) begin
    if (rst) begin
      exec_q <= 1'b0;
    end else begin
      exec_q <= cmd.load;
    end
  end

  // Register result strobe and answer
  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      answer <= 1'b0;
    end else begin
      done   <= exec_q;
      answer <= cmd.do_query & hit;
    end
  end

endmodule

/* rtl/button_click_tracker.sv */
// Top level: configuration registers, controller and datapath of the click tracker.
//
// Usage:
//   Requests enter on func, button_index, pressed and tick_now and are taken
//   at a rising edge where start is high and busy is low. Each request is an
//   event (press or release), one of four queries, or a clear of one button.
//   Every request gives exactly one result: answer with done high for one
//   cycle, registered at the end of the execute state. answer is 0 for events,
//   clears, unused codes, out-of-range buttons and while tracking is off.
//   A request is captured, then executed: the addressed button is read, one
//   32-bit add and compare done and the button written back; busy is high
//   while executing, so no new request is taken until it ends. The result
//   port has no back-pressure; done is a plain strobe. Windows are set over
//   the APB-style port at byte addresses 0, 4, 8, 12 (enable, double-click,
//   hold, recent window); the user must write them only while idle, as the
//   block does not enforce it. A synchronous reset clears all button state
//   and restores the register defaults: disabled, 500, 60000 and 100 ticks.
module button_click_tracker #(
  parameter int BUTTON_COUNT = btc_pkg::BUTTON_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [btc_pkg::FUNC_W-1:0]      func,
  input  logic [btc_pkg::INDEX_W-1:0]     button_index,
  input  logic                            pressed,
  input  logic [btc_pkg::TICK_W-1:0]      tick_now,
  output logic                            done,
  output logic                            answer,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [btc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [btc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [btc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import btc_pkg::*;

  logic              mouse_enabled;
  logic [TICK_W-1:0] double_click_window;
  logic [TICK_W-1:0] hold_window;
  logic [TICK_W-1:0] recent_window;
  logic [1:0]        reg_index;
  logic              cfg_write;
  dp_cmd_t           cmd;
  dp_status_t        status;

  assign pready    = 1'b1;
  assign reg_index = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel & penable & pwrite & pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mouse_enabled       <= 1'b0;
      double_click_window <= DOUBLE_CLICK_WINDOW_RST;
      hold_window         <= HOLD_WINDOW_RST;
      recent_window       <= RECENT_WINDOW_RST;
    end else if (cfg_write) begin
      case (reg_index)
        REG_MOUSE_ENABLED:       mouse_enabled       <= pwdata[0];
        REG_DOUBLE_CLICK_WINDOW: double_click_window <= pwdata;
        REG_HOLD_WINDOW:         hold_window         <= pwdata;
        REG_RECENT_WINDOW:       recent_window       <= pwdata;
        default:                 mouse_enabled       <= mouse_enabled;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_index)
      REG_MOUSE_ENABLED:       prdata = {{(CFG_DATA_W-1){1'b0}}, mouse_enabled};
      REG_DOUBLE_CLICK_WINDOW: prdata = double_click_window;
      REG_HOLD_WINDOW:         prdata = hold_window;
      REG_RECENT_WINDOW:       prdata = recent_window;
      default:                 prdata = '0;
    endcase
  end

  btc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .mouse_enabled (mouse_enabled),
    .status        (status),
    .cmd           (cmd),
    .busy          (busy)
  );

  btc_dp #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .func                (func),
    .button_index        (button_index),
    .pressed             (pressed),
    .tick_now            (tick_now),
    .double_click_window (double_click_window),
    .hold_window         (hold_window),
    .recent_window       (recent_window),
    .status              (status),
    .done                (done),
    .answer              (answer)
  );

  // Every taken request executes in the following cycle
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("request taken but no execute cycle");

  // Execution is followed in the next cycle by the result strobe, with busy low again
  assert property (@(posedge clk) disable iff (rst) busy |=> (!busy && done))
    else $error("execute cycle without a following result");

  // A result strobe only follows an execute cycle
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without execution");

  // A set answer only appears with the strobe
  assert property (@(posedge clk) disable iff (rst) answer |-> done)
    else $error("answer set outside a result");

endmodule
